### design/mqbrr_pkg.sv
// ----------------------------------------------------------------------------
// mqbrr_pkg
// shared constants, codes and types of the burst round-robin queue scheduler
// ----------------------------------------------------------------------------
package mqbrr_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_WORDS   = 4;

    localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int WORD_W = 64;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ENABLE  = 3'd0,
        REG_BURST0  = 3'd1,
        REG_BURST1  = 3'd2,
        REG_BURST2  = 3'd3,
        REG_BURST3  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_SEND  = 2'd1,
        KIND_REVAL = 2'd2,
        KIND_INVAL = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SENT      = 3'd1,
        ST_NONE      = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_SIZE_ERR  = 3'd4,
        ST_FULL      = 3'd5,
        ST_FLUSHED   = 3'd6,
        ST_BAD_QUEUE = 3'd7
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [3:0]      enable;
        logic [3:0][7:0] burst;
    } cfg_t;

    typedef struct packed {
        logic [2:0]                        size;
        logic [MAX_WORDS-1:0][WORD_W-1:0] words;
    } msg_entry_t;

endpackage

### design/mqbrr_if.sv
// ----------------------------------------------------------------------------
// mqbrr_in_if / mqbrr_out_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface mqbrr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  queue_index;
    logic [2:0]  msg_size;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic        send_rejected;

    modport source (output valid, kind, queue_index, msg_size, word0, word1, word2, word3,
                    send_rejected, input ready);
    modport sink   (input valid, kind, queue_index, msg_size, word0, word1, word2, word3,
                    send_rejected, output ready);
endinterface

interface mqbrr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  out_queue;
    logic [2:0]  out_size;
    logic [4:0]  queue_level;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;

    modport source (output valid, status, out_queue, out_size, queue_level, out_word0,
                    out_word1, out_word2, out_word3, input ready);
    modport sink   (input valid, status, out_queue, out_size, queue_level, out_word0,
                    out_word1, out_word2, out_word3, output ready);
endinterface

### design/mqbrr_cfg.sv
// ----------------------------------------------------------------------------
// mqbrr_cfg
// apb register file: queue enable mask and per-queue burst counts
// ----------------------------------------------------------------------------
module mqbrr_cfg
    import mqbrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 4'hf;
            cfg_reg.burst  <= {4{8'd1}};
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ENABLE: cfg_reg.enable   <= pwdata[3:0];
                REG_BURST0: cfg_reg.burst[0] <= pwdata[7:0];
                REG_BURST1: cfg_reg.burst[1] <= pwdata[7:0];
                REG_BURST2: cfg_reg.burst[2] <= pwdata[7:0];
                REG_BURST3: cfg_reg.burst[3] <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE: prdata = {28'd0, cfg_reg.enable};
            REG_BURST0: prdata = {24'd0, cfg_reg.burst[0]};
            REG_BURST1: prdata = {24'd0, cfg_reg.burst[1]};
            REG_BURST2: prdata = {24'd0, cfg_reg.burst[2]};
            REG_BURST3: prdata = {24'd0, cfg_reg.burst[3]};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

### design/mqbrr_msg_store.sv
// ----------------------------------------------------------------------------
// mqbrr_msg_store
// message memory, one entry per queue slot, registered read
// ----------------------------------------------------------------------------
module mqbrr_msg_store
    import mqbrr_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  msg_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output msg_entry_t        rd_data
);

    msg_entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/mqbrr_sched.sv
// ----------------------------------------------------------------------------
// mqbrr_sched
// queue pointers, round-robin burst selection and result register
// ----------------------------------------------------------------------------
module mqbrr_sched
    import mqbrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    mqbrr_in_if.sink          in_ch,
    mqbrr_out_if.source       out_ch,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_addr,
    output msg_entry_t        wr_data,
    output logic              rd_en,
    output logic [SLOT_W-1:0] rd_addr,
    input  msg_entry_t        rd_data
);

    fsm_t             state_reg, state_next;
    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0] tail_next [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_reg [NUM_QUEUES];
    logic [CNT_W-1:0] cnt_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] inval_reg, inval_next;
    logic [1:0]       cur_reg, cur_next;
    logic [7:0]       used_reg, used_next;

    logic             ovalid_reg, ovalid_next;
    status_t          status_reg, status_next;
    logic [1:0]       oq_reg, oq_next;
    logic [2:0]       osize_reg, osize_next;
    logic [4:0]       level_reg, level_next;
    logic [3:0][63:0] ow_reg, ow_next;

    logic             accept;
    kind_t            kind;
    logic [1:0]       q;
    logic             q_ok;
    logic             found;
    logic [1:0]       sel;
    logic [2:0]       sum;
    logic [1:0]       cand;
    logic [7:0]       burst;
    logic [7:0]       used_base;
    logic [8:0]       used_inc;
    logic [CNT_W-1:0] left;
    logic [63:0]      in_w [4];

    assign in_ch.ready = (state_reg == FSM_IDLE) && !ovalid_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign kind        = kind_t'(in_ch.kind);
    assign q           = in_ch.queue_index;
    assign q_ok        = (32'(q) < NUM_QUEUES) && cfg.enable[q];
    assign in_w[0]     = in_ch.word0;
    assign in_w[1]     = in_ch.word1;
    assign in_w[2]     = in_ch.word2;
    assign in_w[3]     = in_ch.word3;

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.out_queue   = oq_reg;
    assign out_ch.out_size    = osize_reg;
    assign out_ch.queue_level = level_reg;
    assign out_ch.out_word0   = ow_reg[0];
    assign out_ch.out_word1   = ow_reg[1];
    assign out_ch.out_word2   = ow_reg[2];
    assign out_ch.out_word3   = ow_reg[3];

    // scan enabled non-empty queues from the current pointer
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        sum   = '0;
        cand  = '0;
        for (int n = 0; n < NUM_QUEUES; n++)
        begin
            sum  = 3'(cur_reg) + 3'(n);
            cand = (32'(sum) >= NUM_QUEUES) ? 2'(32'(sum) - NUM_QUEUES) : sum[1:0];
            if (!found && cfg.enable[cand] && (cnt_reg[cand] != '0))
            begin
                found = 1'b1;
                sel   = cand;
            end
        end
    end

    assign burst     = (cfg.burst[sel] == 8'd0) ? 8'd1 : cfg.burst[sel];
    assign used_base = (sel != cur_reg) ? 8'd0 : used_reg;
    assign used_inc  = 9'(used_base) + 9'd1;
    assign left      = cnt_reg[sel] - CNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        inval_next  = inval_reg;
        cur_next    = cur_reg;
        used_next   = used_reg;
        ovalid_next = ovalid_reg;
        status_next = status_reg;
        oq_next     = oq_reg;
        osize_next  = osize_reg;
        level_next  = level_reg;
        ow_next     = ow_reg;
        wr_en       = 1'b0;
        wr_addr     = SLOT_W'(SLOT_W'(q) * SLOT_W'(QUEUE_DEPTH)) + SLOT_W'(tail_reg[q]);
        wr_data.size = in_ch.msg_size;
        for (int i = 0; i < MAX_WORDS; i++)
        begin
            wr_data.words[i] = (i < 32'(in_ch.msg_size)) ? in_w[i] : 64'd0;
        end
        rd_en       = 1'b0;
        rd_addr     = SLOT_W'(SLOT_W'(sel) * SLOT_W'(QUEUE_DEPTH)) + SLOT_W'(head_reg[sel]);

        if (out_ch.valid && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    ovalid_next = 1'b1;
                    status_next = ST_OK;
                    oq_next     = q;
                    osize_next  = 3'd0;
                    level_next  = 5'd0;
                    ow_next     = '0;
                    case (kind)
                        KIND_ENQ:
                        begin
                            if (!q_ok)
                            begin
                                status_next = ST_BAD_QUEUE;
                            end
                            else if (32'(in_ch.msg_size) > MAX_WORDS)
                            begin
                                status_next = ST_SIZE_ERR;
                                level_next  = 5'(cnt_reg[q]);
                            end
                            else if (inval_reg[q])
                            begin
                                status_next = ST_IGNORED;
                                level_next  = 5'(cnt_reg[q]);
                            end
                            else if (32'(cnt_reg[q]) >= QUEUE_DEPTH)
                            begin
                                status_next = ST_FULL;
                                level_next  = 5'(cnt_reg[q]);
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                tail_next[q] = (32'(tail_reg[q]) == QUEUE_DEPTH - 1) ?
                                               '0 : tail_reg[q] + PTR_W'(1);
                                cnt_next[q]  = cnt_reg[q] + CNT_W'(1);
                                level_next   = 5'(cnt_reg[q] + CNT_W'(1));
                            end
                        end
                        KIND_SEND:
                        begin
                            if (!found)
                            begin
                                status_next = ST_NONE;
                                oq_next     = cur_reg;
                            end
                            else if (in_ch.send_rejected)
                            begin
                                status_next = ST_FLUSHED;
                                oq_next     = sel;
                                for (int k = 0; k < NUM_QUEUES; k++)
                                begin
                                    head_next[k] = '0;
                                    tail_next[k] = '0;
                                    cnt_next[k]  = '0;
                                end
                                inval_next = '1;
                                cur_next   = 2'd0;
                                used_next  = 8'd0;
                            end
                            else
                            begin
                                // result completes when the message read returns
                                ovalid_next    = 1'b0;
                                state_next     = FSM_READ;
                                rd_en          = 1'b1;
                                status_next    = ST_SENT;
                                oq_next        = sel;
                                level_next     = 5'(left);
                                head_next[sel] = (32'(head_reg[sel]) == QUEUE_DEPTH - 1) ?
                                                 '0 : head_reg[sel] + PTR_W'(1);
                                cnt_next[sel]  = left;
                                if ((used_inc >= 9'(burst)) || (left == '0))
                                begin
                                    cur_next  = (32'(sel) == NUM_QUEUES - 1) ?
                                                2'd0 : sel + 2'd1;
                                    used_next = 8'd0;
                                end
                                else
                                begin
                                    cur_next  = sel;
                                    used_next = used_inc[7:0];
                                end
                            end
                        end
                        KIND_REVAL:
                        begin
                            if (!q_ok)
                            begin
                                status_next = ST_BAD_QUEUE;
                            end
                            else
                            begin
                                inval_next[q] = 1'b0;
                                level_next    = 5'(cnt_reg[q]);
                            end
                        end
                        default:
                        begin
                            oq_next = 2'd0;
                            for (int k = 0; k < NUM_QUEUES; k++)
                            begin
                                head_next[k] = '0;
                                tail_next[k] = '0;
                                cnt_next[k]  = '0;
                            end
                            inval_next = '1;
                            cur_next   = 2'd0;
                            used_next  = 8'd0;
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                ovalid_next = 1'b1;
                osize_next  = rd_data.size;
                for (int i = 0; i < 4; i++)
                begin
                    ow_next[i] = (i < MAX_WORDS) ? rd_data.words[i % MAX_WORDS] : 64'd0;
                end
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
            inval_reg  <= '0;
            cur_reg    <= 2'd0;
            used_reg   <= 8'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            inval_reg  <= inval_next;
            cur_reg    <= cur_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        oq_reg     <= oq_next;
        osize_reg  <= osize_next;
        level_reg  <= level_next;
        ow_reg     <= ow_next;
    end

    a_read_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_READ) |-> !ovalid_reg)
        else $error("result pending during message read");

    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_READ) |=> (ovalid_reg && (state_reg == FSM_IDLE)))
        else $error("message read did not produce a result");

    a_send_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_SEND) && found && !in_ch.send_rejected)
        |=> (state_reg == FSM_READ))
        else $error("send step did not start a read");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg[0]) <= QUEUE_DEPTH)
        else $error("queue count above depth");

endmodule

### design/multi_queue_burst_round_robin.sv
// ----------------------------------------------------------------------------
// multi_queue_burst_round_robin
// burst round-robin scheduler over several message queues
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one request item: enqueue, send step, revalidate a queue
//   or invalidate all. out_ch returns exactly one result item per request.
//   registers (apb, byte address 4*i): queue enable mask, burst count per
//   queue; write only while no item is in flight.
// result timing and item flow:
//   enqueue, revalidate, invalidate and non-delivering send steps give their
//   result in the cycle after the item is taken; a send step that delivers a
//   message passes through the registered read of the message memory and then
//   the output register. a new item is taken only once the previous result
//   has left the output register.
// reset:
//   all queues empty and valid, pointer at queue 0, enable mask all ones,
//   burst counts 1. message memory is not cleared.
// stall:
//   a result holds in the output register while out_ch.ready is low and no
//   new item is taken.
// ----------------------------------------------------------------------------
module multi_queue_burst_round_robin
    import mqbrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mqbrr_in_if.sink          in_ch,
    mqbrr_out_if.source       out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t              cfg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    msg_entry_t        wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    msg_entry_t        rd_data;

    mqbrr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mqbrr_msg_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mqbrr_sched u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### tb/mqbrr_checker.sv
// ----------------------------------------------------------------------------
// mqbrr_checker
// Watches the request, result and register ports of the burst round-robin
// scheduler. It keeps its own copy of the queues, pointers and registers,
// works out the result of every accepted request and compares it field by
// field with the results that the block returns, oldest first.
// ----------------------------------------------------------------------------
module mqbrr_checker
    import mqbrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mqbrr_in_if               in_ch,
    mqbrr_out_if              out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        status_t          status;
        logic [1:0]       queue;
        logic [2:0]       size;
        logic [4:0]       level;
        logic [3:0][63:0] words;
    } sched_result_t;

    logic [63:0] slot_words [SLOTS][MAX_WORDS];
    logic [2:0]  slot_size  [SLOTS];
    logic [3:0]  head_ptr   [NUM_QUEUES];
    logic [3:0]  tail_ptr   [NUM_QUEUES];
    logic [4:0]  msg_count  [NUM_QUEUES];
    logic        invalid_q  [NUM_QUEUES];
    logic [1:0]  cur_queue;
    logic [7:0]  burst_cnt;
    logic [3:0]  enable_mask;
    logic [7:0]  burst_limit [4];

    sched_result_t due_results [$];

    function automatic bit queue_usable(logic [1:0] q);
        return enable_mask[q];
    endfunction

    function automatic void flush_queues();
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            head_ptr[q]  = '0;
            tail_ptr[q]  = '0;
            msg_count[q] = '0;
            invalid_q[q] = 1'b1;
        end
        cur_queue = '0;
        burst_cnt = '0;
    endfunction

    function automatic sched_result_t schedule_step(kind_t kind, logic [1:0] q,
                                                    logic [2:0] size,
                                                    logic [3:0][63:0] words,
                                                    logic rejected);
        sched_result_t r;
        int            slot;
        logic [1:0]    sel;
        logic [1:0]    c;
        bit            found;
        int            lim;
        r = '0;
        r.status = ST_OK;
        r.queue = q;
        sel = '0;
        found = 0;
        case (kind)
            KIND_ENQ:
            begin
                if (!queue_usable(q))
                    r.status = ST_BAD_QUEUE;
                else if (size > MAX_WORDS)
                begin
                    r.status = ST_SIZE_ERR;
                    r.level = msg_count[q];
                end
                else if (invalid_q[q])
                begin
                    r.status = ST_IGNORED;
                    r.level = msg_count[q];
                end
                else if (msg_count[q] >= QUEUE_DEPTH)
                begin
                    r.status = ST_FULL;
                    r.level = msg_count[q];
                end
                else
                begin
                    slot = q * QUEUE_DEPTH + tail_ptr[q];
                    for (int i = 0; i < MAX_WORDS; i++)
                        slot_words[slot][i] = (i < size) ? words[i] : 64'd0;
                    slot_size[slot] = size;
                    tail_ptr[q] = tail_ptr[q] + 1'b1;
                    msg_count[q] = msg_count[q] + 1'b1;
                    r.level = msg_count[q];
                end
            end
            KIND_SEND:
            begin
                for (int n = 0; n < NUM_QUEUES; n++)
                begin
                    c = cur_queue + n[1:0];
                    if (!found && queue_usable(c) && msg_count[c] != 0)
                    begin
                        sel = c;
                        found = 1;
                    end
                end
                if (!found)
                begin
                    r.status = ST_NONE;
                    r.queue = cur_queue;
                end
                else
                begin
                    if (sel != cur_queue)
                    begin
                        cur_queue = sel;
                        burst_cnt = '0;
                    end
                    r.queue = sel;
                    if (rejected)
                    begin
                        r.status = ST_FLUSHED;
                        flush_queues();
                    end
                    else
                    begin
                        slot = sel * QUEUE_DEPTH + head_ptr[sel];
                        r.status = ST_SENT;
                        r.size = slot_size[slot];
                        for (int i = 0; i < MAX_WORDS; i++)
                            r.words[i] = slot_words[slot][i];
                        head_ptr[sel] = head_ptr[sel] + 1'b1;
                        msg_count[sel] = msg_count[sel] - 1'b1;
                        r.level = msg_count[sel];
                        burst_cnt = burst_cnt + 1'b1;
                        lim = (burst_limit[sel] == 0) ? 1 : int'(burst_limit[sel]);
                        if (burst_cnt >= lim || msg_count[sel] == 0)
                        begin
                            cur_queue = sel + 1'b1;
                            burst_cnt = '0;
                        end
                    end
                end
            end
            KIND_REVAL:
            begin
                if (!queue_usable(q))
                    r.status = ST_BAD_QUEUE;
                else
                begin
                    invalid_q[q] = 1'b0;
                    r.level = msg_count[q];
                end
            end
            default:
            begin
                flush_queues();
                r.queue = '0;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got;
        sched_result_t want;
        logic [2:0]    reg_index;
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_ptr[q]  = '0;
                tail_ptr[q]  = '0;
                msg_count[q] = '0;
                invalid_q[q] = 1'b0;
                burst_limit[q] = 8'd1;
            end
            cur_queue   = '0;
            burst_cnt   = '0;
            enable_mask = 4'hf;
            due_results.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = status_t'(out_ch.status);
                got.queue  = out_ch.out_queue;
                got.size   = out_ch.out_size;
                got.level  = out_ch.queue_level;
                got.words  = {out_ch.out_word3, out_ch.out_word2,
                              out_ch.out_word1, out_ch.out_word0};
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: status %0d queue %0d",
                                 got.status, got.queue);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("mismatch: expected st %0d q %0d sz %0d lvl %0d ",
                                   want.status, want.queue, want.size, want.level);
                            $write("w %h %h %h %h, ", want.words[0], want.words[1],
                                   want.words[2], want.words[3]);
                            $write("got st %0d q %0d sz %0d lvl %0d ",
                                   got.status, got.queue, got.size, got.level);
                            $display("w %h %h %h %h", got.words[0], got.words[1],
                                     got.words[2], got.words[3]);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                due_results.push_back(schedule_step(kind_t'(in_ch.kind), in_ch.queue_index,
                    in_ch.msg_size,
                    {in_ch.word3, in_ch.word2, in_ch.word1, in_ch.word0},
                    in_ch.send_rejected));
            if (psel && penable && pwrite && pready)
            begin
                reg_index = paddr[4:2];
                if (reg_index == REG_ENABLE)
                    enable_mask = pwdata[3:0];
                else if (reg_index <= REG_BURST3)
                    burst_limit[reg_index - 3'd1] = pwdata[7:0];
            end
            pending = due_results.size();
        end
    end

endmodule

### tb/tb_multi_queue_burst_round_robin.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_burst_round_robin
// Drives request items into the burst round-robin scheduler under several
// register settings and idling patterns, with one long receiver hold-off.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_multi_queue_burst_round_robin;
    import mqbrr_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                tx_idle;
    int                rx_idle;
    int                hold_left;
    int                cycles;

    mqbrr_in_if  req_ch ();
    mqbrr_out_if res_ch ();

    multi_queue_burst_round_robin u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mqbrr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (req_ch),
        .out_ch     (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 300000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic push_request(kind_t kind, logic [1:0] q, logic [2:0] size,
                                logic [3:0][63:0] words, logic rejected);
        while ($urandom_range(99) < tx_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.queue_index   <= q;
        req_ch.msg_size      <= size;
        req_ch.word0         <= words[0];
        req_ch.word1         <= words[1];
        req_ch.word2         <= words[2];
        req_ch.word3         <= words[3];
        req_ch.send_rejected <= rejected;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function automatic logic [3:0][63:0] random_words();
        logic [3:0][63:0] w;
        for (int i = 0; i < 4; i++)
            w[i] = {$urandom, $urandom};
        return w;
    endfunction

    task automatic random_request(int enq_pct, int fav_queue);
        int          pick;
        logic [1:0]  q;
        logic [2:0]  size;
        pick = $urandom_range(99);
        q = ($urandom_range(3) == 0 || fav_queue < 0) ? 2'($urandom_range(3))
                                                      : 2'(fav_queue);
        size = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        if (pick < enq_pct)
            push_request(KIND_ENQ, q, size, random_words(), 1'($urandom_range(1)));
        else if (pick < 88)
            push_request(KIND_SEND, q, size, random_words(), $urandom_range(24) == 0);
        else if (pick < 97)
            push_request(KIND_REVAL, q, size, random_words(), 1'b0);
        else
            push_request(KIND_INVAL, q, size, random_words(), 1'b0);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(index) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [3:0] mask, logic [7:0] b0, logic [7:0] b1,
                            logic [7:0] b2, logic [7:0] b3);
        reg_write(REG_ENABLE, 32'(mask));
        reg_write(REG_BURST0, 32'(b0));
        reg_write(REG_BURST1, 32'(b1));
        reg_write(REG_BURST2, 32'(b2));
        reg_write(REG_BURST3, 32'(b3));
    endtask

    task automatic random_phase(int count, int enq_pct, int fav_queue);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(15) == 0)
                push_request(KIND_REVAL, 2'($urandom_range(3)), '0, '0, 1'b0);
            random_request(enq_pct, fav_queue);
        end
    endtask

    initial
    begin
        logic [3:0][63:0] ones;
        ones = {4{64'hffff_ffff_ffff_ffff}};
        rst_n = 1'b0;
        cycles = 0;
        hold_left = 0;
        tx_idle = 36;
        rx_idle = 47;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        res_ch.ready = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_ENQ;
        req_ch.queue_index = '0;
        req_ch.msg_size = '0;
        req_ch.word0 = '0;
        req_ch.word1 = '0;
        req_ch.word2 = '0;
        req_ch.word3 = '0;
        req_ch.send_rejected = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under reset settings
        push_request(KIND_SEND, 2'd0, 3'd0, '0, 1'b0);
        push_request(KIND_ENQ, 2'd0, 3'd4, ones, 1'b0);
        push_request(KIND_ENQ, 2'd1, 3'd0, ones, 1'b1);
        push_request(KIND_ENQ, 2'd2, 3'd3, random_words(), 1'b0);
        push_request(KIND_ENQ, 2'd3, 3'd1, '0, 1'b0);
        push_request(KIND_ENQ, 2'd3, 3'd5, ones, 1'b0);
        push_request(KIND_ENQ, 2'd3, 3'd7, ones, 1'b0);
        push_request(KIND_SEND, 2'd0, 3'd0, '0, 1'b0);
        push_request(KIND_SEND, 2'd0, 3'd0, '0, 1'b0);
        push_request(KIND_SEND, 2'd0, 3'd0, '0, 1'b1);
        push_request(KIND_ENQ, 2'd0, 3'd2, ones, 1'b0);
        push_request(KIND_SEND, 2'd0, 3'd0, '0, 1'b0);
        push_request(KIND_REVAL, 2'd0, 3'd0, '0, 1'b0);
        push_request(KIND_REVAL, 2'd3, 3'd0, '0, 1'b0);
        push_request(KIND_ENQ, 2'd3, 3'd4, ones, 1'b0);
        push_request(KIND_INVAL, 2'd2, 3'd0, '0, 1'b0);
        push_request(KIND_ENQ, 2'd3, 3'd4, ones, 1'b0);
        push_request(KIND_REVAL, 2'd1, 3'd0, '0, 1'b0);
        push_request(KIND_REVAL, 2'd2, 3'd0, '0, 1'b0);
        drain();

        set_regs(4'b1011, 8'd0, 8'd255, 8'd3, 8'd2);
        push_request(KIND_ENQ, 2'd2, 3'd1, ones, 1'b0);
        push_request(KIND_REVAL, 2'd2, 3'd0, '0, 1'b0);
        random_phase(110, 55, -1);

        // long receiver hold-off while requests keep coming
        hold_left = 400;
        random_phase(30, 60, -1);
        drain();

        set_regs(4'b1111, 8'd255, 8'd0, 8'd1, 8'd4);
        tx_idle = 47;
        rx_idle = 36;
        for (int q = 0; q < 4; q++)
            push_request(KIND_REVAL, 2'(q), '0, '0, 1'b0);
        random_phase(40, 85, 1);
        random_phase(80, 50, -1);
        drain();

        set_regs(4'b0000, 8'd1, 8'd1, 8'd1, 8'd1);
        random_phase(15, 50, -1);
        drain();

        set_regs(4'b1111, 8'd2, 8'd3, 8'd255, 8'd0);
        tx_idle = 0;
        rx_idle = 0;
        for (int q = 0; q < 4; q++)
            push_request(KIND_REVAL, 2'(q), '0, '0, 1'b0);
        random_phase(40, 85, 3);
        random_phase(100, 52, -1);
        drain();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
